/* rtl/nau_pkg.sv */
// ============================================================================
// nau_pkg: shared types, constants and helpers of the activation unit
// Fixed-point constants, opcode codes, the sideband record that rides along
// the pipeline, and the rounding right shift used by the arithmetic stages.
// ============================================================================
package nau_pkg;

    // Number format of the operand and the result.
    localparam int FRACTION_BITS        = 16;
    localparam int OPND_W               = 24;
    localparam int SLOPE_W              = 16;
    localparam int OP_W                 = 3;
    localparam int TANH_TABLE_SIZE_DFLT = 256;
    localparam logic [SLOPE_W-1:0] LEAK_SLOPE_RST = 16'd655;

    // Internal values are Q24; the tanh table spans [0, 4), i.e. 2^26 in Q24.
    localparam int IQ         = 24;
    localparam int SPAN_SHIFT = 26;

    // Q30 constants: k = sqrt(2/pi), a = 0.044715 and 3a.
    localparam logic signed [30:0] K_C  = 31'sd856722023;
    localparam logic signed [26:0] A_C  = 27'sd48012366;
    localparam logic signed [28:0] A3_C = 29'sd144037097;

    // One in Q24 and the result range.
    localparam logic signed [63:0] ONE_Q   = 64'sd16777216;
    localparam logic signed [63:0] RES_MAX = 64'sd8388607;
    localparam logic signed [63:0] RES_MIN = -64'sd8388608;

    typedef enum logic [OP_W-1:0] {
        OP_RELU    = 3'd0,
        OP_LEAKY   = 3'd1,
        OP_GELU    = 3'd2,
        OP_RELU_D  = 3'd3,
        OP_LEAKY_D = 3'd4,
        OP_GELU_D  = 3'd5
    } t_op;

    // Values that travel with an item past the tanh evaluation.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [OPND_W-1:0] x;
        logic signed [27:0]       xq;
        logic signed [26:0]       p;
        logic signed [24:0]       lk;
    } t_side;

    // Right shift that rounds half up, toward plus infinity.
    function automatic logic signed [63:0] f_rsh(input logic signed [63:0] v, input int s);
        logic signed [63:0] half;
        half = (s == 0) ? 64'sd0 : (64'sd1 <<< (s - 1));
        return (v + half) >>> s;
    endfunction

endpackage

/* rtl/neural_activation_unit.sv */
// ============================================================================
// neural_activation_unit: ReLU / leaky ReLU / GELU and derivatives
// Signed Q8.16 operand in, saturated Q8.16 result out, one beat per cycle.
// ============================================================================
//
//  channel   ports                               direction  handshake
//  -------   ---------------------------------   ---------  -----------------
//  input     i_opcode, i_operand_value           in         i_start, o_busy
//  result    o_result_value                      out        o_done strobe
//  config    i_cfg_wr_data (leak slope)          in         i_cfg_wr_en
//
// A beat is taken in every cycle that i_start is high; o_busy stays low.
// Each result appears with o_done once its input beat has passed the
// arithmetic chain: five argument stages, four tanh stages
// (one of them the registered table read) and five output stages.
// Reset clears only the valid bits and restores the leak slope to 655.
// The receiver cannot stall, so the pipeline never holds.
// ============================================================================
module neural_activation_unit
    import nau_pkg::*;
#(
    parameter int TANH_TABLE_SIZE = TANH_TABLE_SIZE_DFLT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [OPND_W-1:0] i_operand_value,
    output logic                     o_done,
    output logic signed [OPND_W-1:0] o_result_value,
    input  logic                     i_cfg_wr_en,
    input  logic [SLOPE_W-1:0]       i_cfg_wr_data
);

    logic [SLOPE_W-1:0] r_leak_slope;
    logic               arg_valid, tanh_valid, in_beat;
    t_side              arg_side, tanh_side;
    logic signed [28:0] arg_z;
    logic signed [25:0] tanh_t;

    // The pipeline takes a beat every cycle.
    assign o_busy  = 1'b0;
    assign in_beat = i_start & ~o_busy;

    // Leak slope register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak_slope <= LEAK_SLOPE_RST;
        end else if (i_cfg_wr_en) begin
            r_leak_slope <= i_cfg_wr_data;
        end
    end

    nau_arg u_arg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_beat),
        .i_opcode (i_opcode),
        .i_x      (i_operand_value),
        .i_slope  (r_leak_slope),
        .o_valid  (arg_valid),
        .o_side   (arg_side),
        .o_z      (arg_z)
    );

    nau_tanh #(
        .TANH_TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (arg_valid),
        .i_side  (arg_side),
        .i_z     (arg_z),
        .o_valid (tanh_valid),
        .o_side  (tanh_side),
        .o_t     (tanh_t)
    );

    nau_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (tanh_valid),
        .i_side   (tanh_side),
        .i_t      (tanh_t),
        .i_slope  (r_leak_slope),
        .o_valid  (o_done),
        .o_result (o_result_value)
    );

endmodule

/* rtl/nau_arg.sv */
// ============================================================================
// nau_arg: GELU tanh argument pipeline
// Clamps the operand, forms x^2, x^3 and the tanh argument k*(x + a*x^3)
// over five register stages; also forms the leaky product and the
// derivative polynomial 1 + 3a*x^2 for later stages.
// ============================================================================
module nau_arg
    import nau_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [OPND_W-1:0] i_x,
    input  logic [SLOPE_W-1:0]       i_slope,
    output logic                     o_valid,
    output t_side                    o_side,
    output logic signed [28:0]       o_z
);

    localparam logic signed [63:0] LIM = 64'sd4 <<< FRACTION_BITS;

    // Stage registers and their next values.
    logic                     r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [OP_W-1:0]          r_op1, r_op2, r_op3, r_op4, r_op5;
    logic signed [OPND_W-1:0] r_x1, r_x2, r_x3v, r_x4, r_x5;
    logic signed [27:0]       r_xq2, r_xq3, r_xq4, r_xq5;
    logic signed [29:0]       r_sq2;
    logic signed [24:0]       r_lk2, r_lk3, r_lk4, r_lk5;
    logic signed [31:0]       r_cu3;
    logic signed [26:0]       r_p3, r_p4, r_p5;
    logic signed [28:0]       r_in4, r_z5;

    logic signed [27:0]       n_xq;
    logic signed [29:0]       n_sq;
    logic signed [24:0]       n_lk;
    logic signed [31:0]       n_cu;
    logic signed [26:0]       n_p;
    logic signed [28:0]       n_in, n_z;

    logic signed [63:0]       xc, xq64, sq64, lk64, cu64, p64, in64, z64;
    logic signed [55:0]       sq_prod;
    logic signed [40:0]       lk_prod;
    logic signed [57:0]       cu_prod;
    logic signed [58:0]       p_prod, a_prod;
    logic signed [59:0]       z_prod;

    // Clamp to [-4, 4], move to Q24, square; leaky product on the raw operand.
    always_comb begin
        xc      = (r_x1 > LIM) ? LIM : ((r_x1 < -LIM) ? -LIM : 64'(r_x1));
        xq64    = xc <<< (IQ - FRACTION_BITS);
        n_xq    = xq64[27:0];
        sq_prod = n_xq * n_xq;
        sq64    = f_rsh(sq_prod, IQ);
        n_sq    = sq64[29:0];
        lk_prod = r_x1 * $signed({1'b0, i_slope});
        lk64    = f_rsh(lk_prod, 16);
        n_lk    = lk64[24:0];
    end

    // Cube and the derivative polynomial.
    always_comb begin
        cu_prod = r_sq2 * r_xq2;
        cu64    = f_rsh(cu_prod, IQ);
        n_cu    = cu64[31:0];
        p_prod  = A3_C * r_sq2;
        p64     = ONE_Q + f_rsh(p_prod, 30);
        n_p     = p64[26:0];
    end

    // Inner sum x + a*x^3, then the scaled tanh argument.
    always_comb begin
        a_prod = A_C * r_cu3;
        in64   = 64'(r_xq3) + f_rsh(a_prod, 30);
        n_in   = in64[28:0];
        z_prod = K_C * r_in4;
        z64    = f_rsh(z_prod, 30);
        n_z    = z64[28:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op1 <= i_opcode;
        r_x1  <= i_x;
        r_op2 <= r_op1;
        r_x2  <= r_x1;
        r_xq2 <= n_xq;
        r_sq2 <= n_sq;
        r_lk2 <= n_lk;
        r_op3 <= r_op2;
        r_x3v <= r_x2;
        r_xq3 <= r_xq2;
        r_lk3 <= r_lk2;
        r_cu3 <= n_cu;
        r_p3  <= n_p;
        r_op4 <= r_op3;
        r_x4  <= r_x3v;
        r_xq4 <= r_xq3;
        r_lk4 <= r_lk3;
        r_p4  <= r_p3;
        r_in4 <= n_in;
        r_op5 <= r_op4;
        r_x5  <= r_x4;
        r_xq5 <= r_xq4;
        r_lk5 <= r_lk4;
        r_p5  <= r_p4;
        r_z5  <= n_z;
    end

    assign o_valid    = r_v5;
    assign o_z        = r_z5;
    assign o_side.op  = r_op5;
    assign o_side.x   = r_x5;
    assign o_side.xq  = r_xq5;
    assign o_side.p   = r_p5;
    assign o_side.lk  = r_lk5;

endmodule

/* rtl/nau_tanh.sv */
// ============================================================================
// nau_tanh: table-based tanh with linear interpolation
// Odd-symmetric tanh of a Q24 argument from a constant table over [0, 4],
// saturating to one beyond; four register stages.
// ============================================================================
module nau_tanh
    import nau_pkg::*;
#(
    parameter int TANH_TABLE_SIZE = TANH_TABLE_SIZE_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic signed [28:0] i_z,
    output logic               o_valid,
    output t_side              o_side,
    output logic signed [25:0] o_t
);

    localparam int W_ADDR = $clog2(TANH_TABLE_SIZE + 1);
    localparam int W_POS  = SPAN_SHIFT + W_ADDR;

    typedef logic [24:0] t_rom [0:TANH_TABLE_SIZE];

    // Unsigned shift-and-subtract quotient, used only while the table is built.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table entry i is round(tanh(u) * 2^24), u = floor(i * 2^26 / size) / 2^24,
    // with e^(2u) from a Taylor series of e^(u/4) and three squarings.
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] u, w, term, sum, den, one;
        one = 64'd1 << IQ;
        for (int i = 0; i <= TANH_TABLE_SIZE; i++) begin
            u    = f_udiv(64'(i) << SPAN_SHIFT, 64'(TANH_TABLE_SIZE));
            w    = u >> 2;
            term = one;
            sum  = one;
            for (int k = 1; k <= 20; k++) begin
                term = f_udiv((term * w) >> IQ, 64'(k));
                sum  = sum + term;
            end
            for (int r = 0; r < 3; r++) begin
                sum = (sum * sum + (one >> 1)) >> IQ;
            end
            den    = sum + one;
            rom[i] = 25'(f_udiv(((sum - one) << IQ) + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam t_rom TANH_ROM = f_build_rom();

    logic                    r_v1, r_v2, r_v3, r_v4;
    t_side                   r_sd1, r_sd2, r_sd3, r_sd4;
    logic [W_ADDR-1:0]       r_idx1;
    logic [SPAN_SHIFT-1:0]   r_fr1, r_fr2;
    logic                    r_neg1, r_neg2, r_neg3;
    logic                    r_sat1, r_sat2, r_sat3;
    logic [24:0]             r_lo2, r_hi2, r_lo3;
    logic signed [26:0]      r_ip3;
    logic signed [25:0]      r_t4;

    logic [28:0]             mag;
    logic [W_POS-1:0]        pos;
    logic signed [25:0]      diff;
    logic signed [52:0]      ip_prod;
    logic signed [63:0]      ip64, t64;
    logic signed [26:0]      n_ip;
    logic signed [25:0]      n_t;

    // Magnitude and table position of the argument.
    always_comb begin
        mag = i_z[28] ? 29'(-i_z) : 29'(i_z);
        pos = W_POS'(mag[SPAN_SHIFT-1:0]) * W_POS'(TANH_TABLE_SIZE);
    end

    // Interpolation between neighboring entries.
    always_comb begin
        diff    = $signed({1'b0, r_hi2}) - $signed({1'b0, r_lo2});
        ip_prod = diff * $signed({1'b0, r_fr2});
        ip64    = f_rsh(ip_prod, SPAN_SHIFT);
        n_ip    = ip64[26:0];
    end

    // Saturation beyond the span and sign restore.
    always_comb begin
        t64 = r_sat3 ? ONE_Q : (64'($signed({1'b0, r_lo3})) + 64'(r_ip3));
        if (r_neg3) begin
            t64 = -t64;
        end
        n_t = t64[25:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload registers; the table read is registered.
    always_ff @(posedge i_clk) begin
        r_sd1  <= i_side;
        r_idx1 <= pos[SPAN_SHIFT +: W_ADDR];
        r_fr1  <= pos[SPAN_SHIFT-1:0];
        r_neg1 <= i_z[28];
        r_sat1 <= (mag[28:SPAN_SHIFT] != '0);
        r_sd2  <= r_sd1;
        r_lo2  <= TANH_ROM[r_idx1];
        r_hi2  <= TANH_ROM[r_idx1 + W_ADDR'(1)];
        r_fr2  <= r_fr1;
        r_neg2 <= r_neg1;
        r_sat2 <= r_sat1;
        r_sd3  <= r_sd2;
        r_lo3  <= r_lo2;
        r_ip3  <= n_ip;
        r_neg3 <= r_neg2;
        r_sat3 <= r_sat2;
        r_sd4  <= r_sd3;
        r_t4   <= n_t;
    end

    assign o_valid = r_v4;
    assign o_side  = r_sd4;
    assign o_t     = r_t4;

endmodule

/* rtl/nau_out.sv */
// ============================================================================
// nau_out: GELU, derivative chain and result selection
// Forms x*(1+t)/2 and the GELU derivative over four multiply stages, then
// selects by opcode and saturates into the output register.
// ============================================================================
module nau_out
    import nau_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_side                    i_side,
    input  logic signed [25:0]       i_t,
    input  logic [SLOPE_W-1:0]       i_slope,
    output logic                     o_valid,
    output logic signed [OPND_W-1:0] o_result
);

    logic                     r_v1, r_v2, r_v3, r_v4, r_v5;
    t_side                    r_sd1, r_sd2, r_sd3, r_sd4;
    logic signed [24:0]       r_g1, r_g2, r_g3, r_g4;
    logic signed [25:0]       r_h1, r_h2, r_h3, r_h4;
    logic signed [25:0]       r_s1;
    logic signed [27:0]       r_m1, r_m2;
    logic signed [28:0]       r_m3;
    logic signed [OPND_W-1:0] r_res;

    logic signed [26:0]       onept;
    logic signed [50:0]       g_prod;
    logic signed [51:0]       tt_prod;
    logic signed [53:0]       m1_prod;
    logic signed [58:0]       m2_prod;
    logic signed [54:0]       m3_prod;
    logic signed [63:0]       g64, s64, h64, m1_64, m2_64, m3_64, d64, r64;
    logic signed [OPND_W-1:0] n_res;

    // GELU value, 1 - t^2 and (1 + t)/2.
    always_comb begin
        onept   = 27'(i_t) + 27'sd16777216;
        g_prod  = i_side.x * onept;
        g64     = f_rsh(g_prod, IQ + 1);
        tt_prod = i_t * i_t;
        s64     = ONE_Q - f_rsh(tt_prod, IQ);
        h64     = f_rsh(onept, 1);
    end

    // Derivative product chain, one multiplier per stage.
    always_comb begin
        m1_prod = r_sd1.xq * r_s1;
        m1_64   = f_rsh(m1_prod, IQ);
        m2_prod = r_m1 * K_C;
        m2_64   = f_rsh(m2_prod, 30);
        m3_prod = r_m2 * r_sd3.p;
        m3_64   = f_rsh(m3_prod, IQ + 1);
    end

    // Opcode selection and saturation.
    always_comb begin
        d64 = 64'(r_h4) + 64'(r_m3);
        case (r_sd4.op)
            OP_RELU:    r64 = (r_sd4.x > 0) ? 64'(r_sd4.x) : 64'sd0;
            OP_LEAKY:   r64 = (r_sd4.x > 0) ? 64'(r_sd4.x) : 64'(r_sd4.lk);
            OP_GELU:    r64 = 64'(r_g4);
            OP_RELU_D:  r64 = (r_sd4.x > 0) ? (64'sd1 <<< FRACTION_BITS) : 64'sd0;
            OP_LEAKY_D: r64 = (r_sd4.x > 0) ? (64'sd1 <<< FRACTION_BITS)
                            : f_rsh($signed({48'd0, i_slope}) <<< FRACTION_BITS, 16);
            OP_GELU_D:  r64 = f_rsh(d64, IQ - FRACTION_BITS);
            default:    r64 = 64'sd0;
        endcase
        if (r64 > RES_MAX) begin
            r64 = RES_MAX;
        end else if (r64 < RES_MIN) begin
            r64 = RES_MIN;
        end
        n_res = r64[OPND_W-1:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sd1 <= i_side;
        r_g1  <= g64[24:0];
        r_s1  <= s64[25:0];
        r_h1  <= h64[25:0];
        r_sd2 <= r_sd1;
        r_g2  <= r_g1;
        r_h2  <= r_h1;
        r_m1  <= m1_64[27:0];
        r_sd3 <= r_sd2;
        r_g3  <= r_g2;
        r_h3  <= r_h2;
        r_m2  <= m2_64[27:0];
        r_sd4 <= r_sd3;
        r_g4  <= r_g3;
        r_h4  <= r_h3;
        r_m3  <= m3_64[28:0];
        r_res <= n_res;
    end

    assign o_valid  = r_v5;
    assign o_result = r_res;

endmodule
